@@ sv/echo_request_tracker_top_macros.svh @@
// ----------------------------------------------------------------------------
// Echo request tracker assertion macros
// Shared concurrent assertion forms for the tracker's checker.
// ----------------------------------------------------------------------------
`ifndef ECHO_REQUEST_TRACKER_TOP_MACROS_SVH
`define ECHO_REQUEST_TRACKER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ERT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ERT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Condition that must hold in the cycle after reset is sampled.
`define ERT_ASSERT_RESET(label, cons, msg) \
  label: assert property (@(posedge clk) !rst_n |=> (cons)) else $error(msg);

`endif

@@ sv/ert_pkg.sv @@
// ----------------------------------------------------------------------------
// Echo request tracker package
// Types, codes and constants shared by the tracker modules.
// ----------------------------------------------------------------------------
package ert_pkg;

  localparam int TABLE_ENTRIES_DEF = 128;
  localparam int QUEUE_DEPTH       = 2;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = CFG_ADDR_W - 2;
  localparam logic [CFG_IDX_W-1:0] REG_ECHO_ID = '0;

  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 96;

  localparam logic CMD_SEND = 1'b0;

  localparam logic [7:0]         TYPE_ECHO_REPLY = 8'd0;
  localparam logic signed [12:0] MIN_ICMP_BYTES  = 13'sd8;

  localparam logic [20:0] USEC_PER_SEC = 21'd1000000;
  localparam logic [9:0]  MS_PER_SEC   = 10'd1000;
  localparam int          USEC_PER_MS  = 1000;
  localparam int          RECIP_SHIFT  = 30;
  localparam logic [20:0] RECIP_MS     =
    21'(((64'd1 << RECIP_SHIFT) + USEC_PER_MS - 1) / USEC_PER_MS);
  localparam int          PROD_W       = 41;

  typedef enum logic [1:0] {
    OP_SEND,
    OP_REPLY,
    OP_SHORT,
    OP_FOREIGN
  } op_t;

  typedef enum logic [2:0] {
    STS_SENT    = 3'd0,
    STS_FULL    = 3'd1,
    STS_MATCHED = 3'd2,
    STS_SHORT   = 3'd3,
    STS_FOREIGN = 3'd4,
    STS_UNKNOWN = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_SCAN,
    BK_CALC,
    BK_MUL,
    BK_SUM,
    BK_OUT
  } back_state_t;

  typedef struct packed {
    op_t                op;
    logic               send_ok;
    logic [31:0]        time_sec;
    logic [19:0]        time_usec;
    logic [15:0]        seq;
    logic signed [12:0] payload;
  } req_t;

  typedef struct packed {
    logic        pending;
    logic [15:0] seq;
    logic [31:0] sent_sec;
    logic [19:0] sent_usec;
  } entry_t;

endpackage

@@ sv/ert_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ert_ram
  import ert_pkg::*;
#(
  parameter int WIDTH = $bits(entry_t),
  parameter int DEPTH = TABLE_ENTRIES_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ sv/ert_queue.sv @@
// ----------------------------------------------------------------------------
// Request queue
// Short FIFO of classified requests between the front and back ends.
// ----------------------------------------------------------------------------
module ert_queue
  import ert_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  req_t push_data,
  output logic full,
  output logic valid,
  input  logic pop,
  output req_t pop_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

  req_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   count_r, count_nxt;

  assign full     = (count_r == (PTR_W + 1)'(QUEUE_DEPTH));
  assign valid    = (count_r != '0);
  assign pop_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ sv/ert_front.sv @@
// ----------------------------------------------------------------------------
// Tracker front end
// Accepts requests, holds the identifier register and classifies each request.
// ----------------------------------------------------------------------------
module ert_front
  import ert_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // send_ok, time_sec, time_usec, ip_header_words, packet_length,
  // message_type, message_id, seq_number
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // command
  input  logic                  in_tuser,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  input  logic                  init_done,
  input  logic                  q_full,
  output logic                  q_push,
  output req_t                  q_data
);

  logic [15:0]        echo_id_r;
  logic               cfg_hit;
  logic               send_ok;
  logic [31:0]        time_sec;
  logic [19:0]        time_usec;
  logic [3:0]         ip_header_words;
  logic [11:0]        packet_length;
  logic [7:0]         message_type;
  logic [15:0]        message_id;
  logic [15:0]        seq_number;
  logic signed [12:0] payload;

  assign send_ok         = in_tdata[0];
  assign time_sec        = in_tdata[32:1];
  assign time_usec       = in_tdata[52:33];
  assign ip_header_words = in_tdata[56:53];
  assign packet_length   = in_tdata[68:57];
  assign message_type    = in_tdata[76:69];
  assign message_id      = in_tdata[92:77];
  assign seq_number      = in_tdata[108:93];

  assign cfg_hit    = (cfg_paddr[CFG_ADDR_W-1:2] == REG_ECHO_ID) && (cfg_paddr[1:0] == 2'b00);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_hit ? {16'd0, echo_id_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      echo_id_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (cfg_paddr[CFG_ADDR_W-1:2] == REG_ECHO_ID)) begin
      echo_id_r <= cfg_pwdata[15:0];
    end
  end

  assign payload   = $signed({1'b0, packet_length}) - $signed({7'd0, ip_header_words, 2'b00});
  assign in_tready = init_done && !q_full;
  assign q_push    = in_tvalid && in_tready;

  always_comb begin
    q_data.send_ok   = send_ok;
    q_data.time_sec  = time_sec;
    q_data.time_usec = time_usec;
    q_data.seq       = seq_number;
    q_data.payload   = payload;
    if (in_tuser == CMD_SEND) begin
      q_data.op      = OP_SEND;
      q_data.payload = '0;
    end else if (payload < MIN_ICMP_BYTES) begin
      q_data.op = OP_SHORT;
    end else if (message_type != TYPE_ECHO_REPLY || message_id != echo_id_r) begin
      q_data.op = OP_FOREIGN;
    end else begin
      q_data.op = OP_REPLY;
    end
  end

endmodule

@@ sv/ert_back.sv @@
// ----------------------------------------------------------------------------
// Tracker back end
// Scans the entry table, updates it, computes the round trip and holds the
// result register.
// ----------------------------------------------------------------------------
module ert_back
  import ert_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  req_t                  q_data,
  output logic                  q_pop,
  output logic                  init_done,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  back_state_t         state_r, state_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [15:0]         send_cnt_r, send_cnt_nxt;
  logic [15:0]         reply_cnt_r, reply_cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  req_t                req_r, req_nxt;
  logic                found_r, found_nxt;
  logic [IDX_W-1:0]    hit_idx_r, hit_idx_nxt;
  entry_t              hit_entry_r, hit_entry_nxt;
  status_t             res_status_r, res_status_nxt;
  logic [15:0]         res_seq_r, res_seq_nxt;
  logic [31:0]         res_rtt_r, res_rtt_nxt;
  logic [31:0]         sec_diff_r, sec_diff_nxt;
  logic [19:0]         usec_abs_r, usec_abs_nxt;
  logic                usec_neg_r, usec_neg_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [31:0]         sec_ms_r, sec_ms_nxt;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  entry_t              ram_wdata;
  logic [IDX_W-1:0]    ram_raddr;
  entry_t              ram_rdata;

  logic                hit;
  logic signed [20:0]  usec_diff;
  logic signed [20:0]  usec_adj;
  logic [31:0]         sec_adj;
  logic [31:0]         usec_ms;

  ert_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign init_done  = (state_r != BK_CLEAR);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    usec_diff = $signed({1'b0, req_r.time_usec}) - $signed({1'b0, hit_entry_r.sent_usec});
    sec_adj   = req_r.time_sec - hit_entry_r.sent_sec;
    usec_adj  = usec_diff;
    if (usec_diff < 0) begin
      sec_adj  = sec_adj - 32'd1;
      usec_adj = usec_diff + $signed(USEC_PER_SEC);
    end
  end

  assign usec_ms = 32'(prod_r[PROD_W-1:RECIP_SHIFT]);

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    send_cnt_nxt   = send_cnt_r;
    reply_cnt_nxt  = reply_cnt_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    req_nxt        = req_r;
    found_nxt      = found_r;
    hit_idx_nxt    = hit_idx_r;
    hit_entry_nxt  = hit_entry_r;
    res_status_nxt = res_status_r;
    res_seq_nxt    = res_seq_r;
    res_rtt_nxt    = res_rtt_r;
    sec_diff_nxt   = sec_diff_r;
    usec_abs_nxt   = usec_abs_r;
    usec_neg_nxt   = usec_neg_r;
    prod_nxt       = prod_r;
    sec_ms_nxt     = sec_ms_r;
    q_pop          = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = idx_r;
    ram_wdata      = '0;
    ram_raddr      = '0;
    hit            = 1'b0;
    case (state_r)
      BK_CLEAR: begin
        ram_we = 1'b1;
        if (idx_r == LAST_IDX) begin
          idx_nxt   = '0;
          state_nxt = BK_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      BK_IDLE: begin
        if (q_valid) begin
          q_pop       = 1'b1;
          req_nxt     = q_data;
          idx_nxt     = '0;
          found_nxt   = 1'b0;
          res_seq_nxt = '0;
          res_rtt_nxt = '0;
          case (q_data.op)
            OP_SEND, OP_REPLY: begin
              state_nxt = BK_SCAN;
            end
            OP_SHORT: begin
              res_status_nxt = STS_SHORT;
              state_nxt      = BK_OUT;
            end
            default: begin
              res_status_nxt = STS_FOREIGN;
              state_nxt      = BK_OUT;
            end
          endcase
        end
      end
      BK_SCAN: begin
        hit = (req_r.op == OP_SEND) ? !ram_rdata.pending : (ram_rdata.seq == req_r.seq);
        if (hit) begin
          found_nxt     = 1'b1;
          hit_idx_nxt   = idx_r;
          hit_entry_nxt = ram_rdata;
          state_nxt     = BK_CALC;
        end else if (idx_r == LAST_IDX) begin
          state_nxt = BK_CALC;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          ram_raddr = idx_r + 1'b1;
        end
      end
      BK_CALC: begin
        if (req_r.op == OP_SEND) begin
          res_seq_nxt    = send_cnt_r;
          res_status_nxt = found_r ? STS_SENT : STS_FULL;
          if (found_r) begin
            ram_we              = 1'b1;
            ram_waddr           = hit_idx_r;
            ram_wdata.pending   = 1'b1;
            ram_wdata.seq       = send_cnt_r;
            ram_wdata.sent_sec  = req_r.time_sec;
            ram_wdata.sent_usec = req_r.time_usec;
          end
          if (req_r.send_ok) begin
            send_cnt_nxt = send_cnt_r + 16'd1;
          end
          state_nxt = BK_OUT;
        end else if (found_r) begin
          ram_we            = 1'b1;
          ram_waddr         = hit_idx_r;
          ram_wdata         = hit_entry_r;
          ram_wdata.pending = 1'b0;
          reply_cnt_nxt     = reply_cnt_r + 16'd1;
          res_seq_nxt       = req_r.seq;
          res_status_nxt    = STS_MATCHED;
          sec_diff_nxt      = sec_adj;
          usec_neg_nxt      = usec_adj[20];
          usec_abs_nxt      = usec_adj[20] ? 20'(-usec_adj) : usec_adj[19:0];
          state_nxt         = BK_MUL;
        end else begin
          res_status_nxt = STS_UNKNOWN;
          state_nxt      = BK_OUT;
        end
      end
      BK_MUL: begin
        prod_nxt   = PROD_W'(usec_abs_r) * PROD_W'(RECIP_MS);
        sec_ms_nxt = 32'(sec_diff_r * 32'(MS_PER_SEC));
        state_nxt  = BK_SUM;
      end
      BK_SUM: begin
        res_rtt_nxt = usec_neg_r ? sec_ms_r - usec_ms : sec_ms_r + usec_ms;
        state_nxt   = BK_OUT;
      end
      BK_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {reply_cnt_r, send_cnt_r, req_r.payload,
                           res_rtt_r, res_seq_r, res_status_r};
          state_nxt     = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      idx_r       <= '0;
      send_cnt_r  <= '0;
      reply_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      send_cnt_r  <= send_cnt_nxt;
      reply_cnt_r <= reply_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r   <= out_data_nxt;
    req_r        <= req_nxt;
    found_r      <= found_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_entry_r  <= hit_entry_nxt;
    res_status_r <= res_status_nxt;
    res_seq_r    <= res_seq_nxt;
    res_rtt_r    <= res_rtt_nxt;
    sec_diff_r   <= sec_diff_nxt;
    usec_abs_r   <= usec_abs_nxt;
    usec_neg_r   <= usec_neg_nxt;
    prod_r       <= prod_nxt;
    sec_ms_r     <= sec_ms_nxt;
  end

endmodule

@@ sv/echo_request_tracker_top.sv @@
// ----------------------------------------------------------------------------
// Echo request tracker
// Tracks outstanding echo requests and reports round trips of their replies.
//
//   Channel  Direction  Carries
//   in_      slave      one request: a send event or a received packet
//   out_     master     one result per request
//   cfg_     slave      APB register access to echo_identifier
//
// A rejected packet skips the table scan. Sends and replies scan the entry
// RAM one entry per cycle through its single read port, stopping at the
// entry that the request claims or matches, or at the last one. After reset
// a clearing pass zeroes the table, with in_tready low. The request queue
// and the result register let input and output stall independently.
// ----------------------------------------------------------------------------
module echo_request_tracker_top
  import ert_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // send_ok, time_sec, time_usec, ip_header_words, packet_length,
  // message_type, message_id, seq_number
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // command
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // status, sequence_used, round_trip_ms, payload_length, sent_total,
  // received_total
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic init_done;
  logic q_full;
  logic q_push;
  logic q_valid;
  logic q_pop;
  req_t q_push_data;
  req_t q_pop_data;

  ert_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .init_done   (init_done),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_push_data)
  );

  ert_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .valid     (q_valid),
    .pop       (q_pop),
    .pop_data  (q_pop_data)
  );

  ert_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_data     (q_pop_data),
    .q_pop      (q_pop),
    .init_done  (init_done),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

@@ sv/ert_checker.sv @@
// ----------------------------------------------------------------------------
// Echo request tracker checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "echo_request_tracker_top_macros.svh"

module ert_checker
  import ert_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  `ERT_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "Result dropped while stalled.")
  `ERT_ASSERT_NEXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata), "Result changed while stalled.")
  `ERT_ASSERT_RESET(a_reset_quiet, !out_tvalid && !in_tready, "Tracker not quiet after reset.")
  `ERT_ASSERT_NOW(a_reject_zero, out_tvalid && (out_tdata[2:0] == STS_SHORT || out_tdata[2:0] == STS_FOREIGN || out_tdata[2:0] == STS_UNKNOWN), out_tdata[50:3] == '0, "Rejected result carries sequence or round trip.")

endmodule

bind echo_request_tracker_top ert_checker u_checker (.*);

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Echo request tracker testbench
// Drives send events and received packets into the tracker through its
// stream input, sets echo_identifier over the APB port between phases, and
// checks every result against a cycle-free model of the entry table kept in
// this file. A short directed table comes first, then random traffic made
// mostly of sends and well-formed replies, with one phase that fills the table.
// ----------------------------------------------------------------------------
module tb;
  import ert_pkg::*;

  localparam logic CMD_REPLY = ~CMD_SEND;
  localparam int   N_ENTRIES = TABLE_ENTRIES_DEF;

  typedef struct packed {
    logic        command;
    logic        send_ok;
    logic [31:0] time_sec;
    logic [19:0] time_usec;
    logic [3:0]  hdr_words;
    logic [11:0] pkt_len;
    logic [7:0]  msg_type;
    logic [15:0] msg_id;
    logic [15:0] seq_number;
  } request_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] seq_used;
    logic [31:0] rtt_ms;
    logic [12:0] payload;
    logic [15:0] sent_total;
    logic [15:0] recv_total;
  } result_t;

  typedef struct {
    request_t req;
    bit       typed;
    result_t  want;
  } stim_row_t;

  typedef enum {MIX_ALL, SENDS_ONLY, REPLIES_ONLY} traffic_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  logic [15:0] tbl_seq     [N_ENTRIES];
  logic        tbl_pending [N_ENTRIES];
  logic [31:0] tbl_sec     [N_ENTRIES];
  logic [19:0] tbl_usec    [N_ENTRIES];
  logic [15:0] next_seq = '0;
  logic [15:0] replies_seen = '0;
  logic [15:0] echo_id = '0;

  result_t     expected_results[$];
  int          error_count = 0;
  int          burst_left = 0;
  logic [31:0] clock_sec = 32'd1000;
  logic [19:0] clock_usec = '0;

  int stall_mode = 0;
  int mode_left = 0;
  int ready_phase = 0;

  echo_request_tracker_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic result_t track_request(request_t r);
    result_t     res;
    int          slot;
    int          payload;
    logic [31:0] sec_d;
    int          usec_d;
    res = '0;
    slot = -1;
    if (r.command == CMD_SEND) begin
      for (int i = 0; i < N_ENTRIES; i++) begin
        if (!tbl_pending[i] && slot < 0) slot = i;
      end
      res.seq_used = next_seq;
      if (slot >= 0) begin
        tbl_seq[slot] = next_seq;
        tbl_pending[slot] = 1'b1;
        tbl_sec[slot] = r.time_sec;
        tbl_usec[slot] = r.time_usec;
        res.status = STS_SENT;
      end else begin
        res.status = STS_FULL;
      end
      if (r.send_ok) next_seq = next_seq + 16'd1;
    end else begin
      payload = int'(r.pkt_len) - 4 * int'(r.hdr_words);
      res.payload = payload[12:0];
      if (payload < int'(MIN_ICMP_BYTES)) begin
        res.status = STS_SHORT;
      end else if (r.msg_type != TYPE_ECHO_REPLY || r.msg_id != echo_id) begin
        res.status = STS_FOREIGN;
      end else begin
        for (int i = 0; i < N_ENTRIES; i++) begin
          if (tbl_seq[i] == r.seq_number && slot < 0) slot = i;
        end
        if (slot < 0) begin
          res.status = STS_UNKNOWN;
        end else begin
          tbl_pending[slot] = 1'b0;
          sec_d = r.time_sec - tbl_sec[slot];
          usec_d = int'(r.time_usec) - int'(tbl_usec[slot]);
          if (usec_d < 0) begin
            sec_d = sec_d - 32'd1;
            usec_d = usec_d + int'(USEC_PER_SEC);
          end
          res.rtt_ms = sec_d * 32'(MS_PER_SEC) + 32'(usec_d / USEC_PER_MS);
          replies_seen = replies_seen + 16'd1;
          res.seq_used = r.seq_number;
          res.status = STS_MATCHED;
        end
      end
    end
    res.sent_total = next_seq;
    res.recv_total = replies_seen;
    return res;
  endfunction

  function automatic request_t rq_send(logic ok, logic [31:0] sec, logic [19:0] usec);
    return '{CMD_SEND, ok, sec, usec, 4'd0, 12'd0, 8'd0, 16'd0, 16'd0};
  endfunction

  function automatic request_t rq_reply(logic [31:0] sec, logic [19:0] usec,
                                        logic [3:0] hdr, logic [11:0] len,
                                        logic [7:0] mtype, logic [15:0] mid,
                                        logic [15:0] seq);
    return '{CMD_REPLY, 1'b0, sec, usec, hdr, len, mtype, mid, seq};
  endfunction

  function automatic request_t random_request(traffic_t mix);
    request_t    r;
    int          pick;
    int          pend[$];
    int          step;
    int          hdr_bytes;
    if ($urandom_range(0, 49) == 0) begin
      clock_sec = $urandom;
      clock_usec = 20'($urandom_range(0, 999999));
    end else begin
      step = int'(clock_usec) + $urandom_range(0, 400000);
      if (step >= int'(USEC_PER_SEC)) begin
        clock_sec = clock_sec + 32'd1;
        step = step - int'(USEC_PER_SEC);
      end
      clock_usec = 20'(step);
      if ($urandom_range(0, 9) == 0) clock_sec = clock_sec + 32'($urandom_range(1, 5));
    end
    r.command = CMD_REPLY;
    r.send_ok = 1'($urandom);
    r.time_sec = clock_sec;
    r.time_usec = clock_usec;
    r.hdr_words = 4'($urandom_range(0, 15));
    r.pkt_len = 12'($urandom_range(0, 2048));
    r.msg_type = 8'($urandom_range(0, 255));
    r.msg_id = 16'($urandom);
    r.seq_number = 16'($urandom);
    for (int i = 0; i < N_ENTRIES; i++) begin
      if (tbl_pending[i]) pend.push_back(i);
    end
    case (mix)
      SENDS_ONLY:   pick = 0;
      REPLIES_ONLY: pick = (pend.size() == 0) ? 90 : 60;
      default:      pick = $urandom_range(0, 99);
    endcase
    if (pend.size() == 0 && pick >= 45 && pick < 85) pick = 0;
    hdr_bytes = 4 * int'(r.hdr_words);
    if (pick < 45) begin
      r.command = CMD_SEND;
      r.send_ok = ($urandom_range(0, 19) != 0);
    end else if (pick < 85) begin
      r.seq_number = tbl_seq[pend[$urandom_range(0, pend.size() - 1)]];
      r.msg_type = TYPE_ECHO_REPLY;
      r.msg_id = echo_id;
      r.pkt_len = 12'(hdr_bytes + $urandom_range(8, 2048 - hdr_bytes));
    end else begin
      r.msg_type = TYPE_ECHO_REPLY;
      r.msg_id = echo_id;
      case ($urandom_range(0, 3))
        0: r.pkt_len = 12'($urandom_range(0, hdr_bytes + 7));
        1: r.msg_type = 8'($urandom_range(1, 255));
        2: r.msg_id = echo_id ^ 16'($urandom_range(1, 65535));
        default: begin
          r.msg_type = ($urandom_range(0, 1) == 0) ? TYPE_ECHO_REPLY : 8'($urandom);
          r.pkt_len = 12'(hdr_bytes + $urandom_range(0, 2048 - hdr_bytes));
        end
      endcase
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_result(logic [OUT_DATA_W-1:0] data);
    result_t got;
    result_t want;
    got.status = status_t'(data[2:0]);
    got.seq_used = data[18:3];
    got.rtt_ms = data[50:19];
    got.payload = data[63:51];
    got.sent_total = data[79:64];
    got.recv_total = data[95:80];
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("result %h with no request waiting", data));
    end else begin
      want = expected_results.pop_front();
      if (got.status != want.status)
        report_mismatch($sformatf("status: expected %0d got %0d",
                                  int'(want.status), int'(got.status)));
      if (got.seq_used != want.seq_used)
        report_mismatch($sformatf("sequence_used: expected %0d got %0d",
                                  want.seq_used, got.seq_used));
      if (got.rtt_ms != want.rtt_ms)
        report_mismatch($sformatf("round_trip_ms: expected %0d got %0d",
                                  $signed(want.rtt_ms), $signed(got.rtt_ms)));
      if (got.payload != want.payload)
        report_mismatch($sformatf("payload_length: expected %0d got %0d",
                                  $signed(want.payload), $signed(got.payload)));
      if (got.sent_total != want.sent_total)
        report_mismatch($sformatf("sent_total: expected %0d got %0d",
                                  want.sent_total, got.sent_total));
      if (got.recv_total != want.recv_total)
        report_mismatch($sformatf("received_total: expected %0d got %0d",
                                  want.recv_total, got.recv_total));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_result(out_tdata);
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left = $urandom_range(20, 120);
    end else begin
      mode_left = mode_left - 1;
    end
    ready_phase = (ready_phase + 1) % 5;
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      2: out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= (ready_phase == 0);
    endcase
  end

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= 32'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (idx == REG_ECHO_ID) echo_id = value;
    @(posedge clk);
  endtask

  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_request(request_t r, bit typed, result_t want);
    result_t predicted;
    in_tvalid <= 1'b1;
    in_tuser <= r.command;
    in_tdata <= {3'b000, r.seq_number, r.msg_id, r.msg_type, r.pkt_len,
                 r.hdr_words, r.time_usec, r.time_sec, r.send_ok};
    do @(posedge clk); while (!in_tready);
    predicted = track_request(r);
    expected_results.push_back(typed ? want : predicted);
    pace_sender();
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic run_traffic(traffic_t mix, int count);
    for (int n = 0; n < count; n++) begin
      send_request(random_request(mix), 1'b0, '0);
      if (n % 150 == 149) wait_drained();
    end
  endtask

  initial begin
    stim_row_t rows[$];
    for (int i = 0; i < N_ENTRIES; i++) begin
      tbl_seq[i] = '0;
      tbl_pending[i] = 1'b0;
      tbl_sec[i] = '0;
      tbl_usec[i] = '0;
    end
    rows.push_back('{rq_reply(32'd0, 20'd0, 4'd5, 12'd28, TYPE_ECHO_REPLY, 16'hA5C3, 16'd0),
                     1'b1, '{STS_MATCHED, 16'd0, 32'd0, 13'd8, 16'd0, 16'd1}});
    rows.push_back('{rq_reply(32'd0, 20'd0, 4'd15, 12'd0, TYPE_ECHO_REPLY, 16'hA5C3, 16'd0),
                     1'b1, '{STS_SHORT, 16'd0, 32'd0, -13'sd60, 16'd0, 16'd1}});
    rows.push_back('{rq_reply(32'd0, 20'd0, 4'd0, 12'd7, TYPE_ECHO_REPLY, 16'hA5C3, 16'd0),
                     1'b1, '{STS_SHORT, 16'd0, 32'd0, 13'd7, 16'd0, 16'd1}});
    rows.push_back('{rq_reply(32'd0, 20'd0, 4'd0, 12'd2048, 8'd8, 16'hA5C3, 16'd5),
                     1'b1, '{STS_FOREIGN, 16'd0, 32'd0, 13'd2048, 16'd0, 16'd1}});
    rows.push_back('{rq_reply(32'd0, 20'd0, 4'd5, 12'd28, TYPE_ECHO_REPLY, 16'h5A3C, 16'd0),
                     1'b1, '{STS_FOREIGN, 16'd0, 32'd0, 13'd8, 16'd0, 16'd1}});
    rows.push_back('{rq_reply(32'hFFFFFFFF, 20'd999999, 4'd15, 12'd2048, 8'hFF, 16'hFFFF,
                              16'hFFFF),
                     1'b1, '{STS_FOREIGN, 16'd0, 32'd0, 13'd1988, 16'd0, 16'd1}});
    rows.push_back('{rq_send(1'b1, 32'd100, 20'd500000),
                     1'b1, '{STS_SENT, 16'd0, 32'd0, 13'd0, 16'd1, 16'd1}});
    rows.push_back('{rq_send(1'b0, 32'hFFFFFFFF, 20'd999999),
                     1'b1, '{STS_SENT, 16'd1, 32'd0, 13'd0, 16'd1, 16'd1}});
    rows.push_back('{rq_send(1'b1, 32'd0, 20'd0), 1'b0, '0});
    rows.push_back('{rq_reply(32'd0, 20'd0, 4'd5, 12'd28, TYPE_ECHO_REPLY, 16'hA5C3, 16'd1),
                     1'b0, '0});
    rows.push_back('{rq_reply(32'd101, 20'd499999, 4'd0, 12'd8, TYPE_ECHO_REPLY, 16'hA5C3,
                              16'd0),
                     1'b0, '0});
    rows.push_back('{rq_reply(32'd7, 20'd3, 4'd15, 12'd68, TYPE_ECHO_REPLY, 16'hA5C3,
                              16'hFFFF),
                     1'b0, '0});
    rows.push_back('{rq_reply(32'hFFFFFFFF, 20'd999999, 4'd5, 12'd2048, TYPE_ECHO_REPLY,
                              16'hA5C3, 16'd1),
                     1'b0, '0});
    rows.push_back('{rq_send(1'b1, 32'hFFFFFFFF, 20'd999999), 1'b0, '0});
    rows.push_back('{rq_reply(32'd0, 20'd0, 4'd5, 12'd28, TYPE_ECHO_REPLY, 16'hA5C3, 16'd2),
                     1'b0, '0});

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_register(REG_ECHO_ID, 16'hA5C3);
    foreach (rows[i]) send_request(rows[i].req, rows[i].typed, rows[i].want);
    wait_drained();

    write_register(REG_ECHO_ID, 16'($urandom));
    run_traffic(MIX_ALL, 500);
    wait_drained();

    write_register(REG_ECHO_ID, 16'hFFFF);
    run_traffic(SENDS_ONLY, N_ENTRIES + 12);
    run_traffic(REPLIES_ONLY, N_ENTRIES + 12);
    run_traffic(MIX_ALL, 450);
    wait_drained();

    write_register(REG_ECHO_ID, 16'h0000);
    run_traffic(MIX_ALL, 400);
    wait_drained();

    repeat (N_ENTRIES + 8) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
